FILE: sv/sscd_pkg.sv
// ----------------------------------------------------------------------------
// sscd_pkg: switch scan change events, shared types
// transaction payloads, per-lane result record and lane count
// ----------------------------------------------------------------------------
`default_nettype none

package sscd_pkg;

    // one lane per bit of a scanned byte
    localparam int unsigned LANES = 8;

    typedef struct packed {
        logic [7:0] scan_byte;
        logic       scan_start;
    } scan_t;

    typedef struct packed {
        logic [5:0] switch_number;
        logic       switch_on;
        logic       last_event;
    } evt_t;

    // what one lane found for its switch
    typedef struct packed {
        logic       change;
        logic       state;
        logic [5:0] number;
    } lane_t;

endpackage

`default_nettype wire

FILE: sv/switch_scan_change_events.sv
// ----------------------------------------------------------------------------
// switch_scan_change_events: switch scan change detector
// compares each scanned byte with the same byte of the previous scan and
// emits one event per changed switch, lowest switch first
// ----------------------------------------------------------------------------
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+---------------------------------------
//  scan    | scan_valid  | scan_stall  | scan_data (scan_byte, scan_start)
//  evt     | evt_valid   | evt_stall   | evt_data (switch_number, switch_on,
//          |             |             |           last_event)
//
//  a byte with changed switches occupies the event serializer until its last
//  event is emitted, and the next byte loads as that event is emitted; a byte
//  with no change does not hold it; a byte passes the lane stage registers and
//  the serializer's pending and lane registers before its first event is output
//  reset clears the previous-scan valid bits and the byte position at once,
//  no clearing pass; an entry never written reads as all zeros
//  evt_stall holds the output register; scan_stall rises only when the lane
//  stage holds a byte that the serializer cannot take
//
`default_nettype none

module switch_scan_change_events #(
    parameter int unsigned SCAN_BYTES = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             scan_valid,
    output logic                  scan_stall,
    input  wire sscd_pkg::scan_t  scan_data,
    output logic                  evt_valid,
    input  wire logic             evt_stall,
    output sscd_pkg::evt_t        evt_data
);
    import sscd_pkg::*;

    localparam int unsigned PW = (SCAN_BYTES > 1) ? $clog2(SCAN_BYTES) : 1;
    localparam logic [PW-1:0] LAST_POS = PW'(SCAN_BYTES - 1);

    // ---- byte position and previous-scan store ----
    logic [PW-1:0]   pos_reg, pos_next;
    logic [PW-1:0]   cur_pos;
    logic [7:0]      now;                     // bit-reversed byte, switch order
    logic            accept;

    logic [7:0]      mem [SCAN_BYTES];        // previous scan, one entry per byte
    logic [SCAN_BYTES-1:0] vld_reg;           // entry written since reset

    // ---- lane stage registers ----
    logic            s1_valid_reg, s1_valid_next;
    logic [7:0]      s1_now_reg;
    logic [PW-1:0]   s1_pos_reg;
    logic [7:0]      rd_reg;                  // registered store read
    logic            rdv_reg;
    logic [7:0]      prev;
    logic [2:0]      pos_low;

    lane_t [LANES-1:0] lanes;
    logic            take;

    // first shifted bit (bit 7) becomes switch 0
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            now[j] = scan_data.scan_byte[7 - j];
        end
    end

    assign scan_stall = s1_valid_reg && !take;
    assign accept     = scan_valid && !scan_stall;

    // scan start forces position zero, wrap after the last byte
    always_comb
    begin
        cur_pos  = scan_data.scan_start ? '0 : pos_reg;
        pos_next = pos_reg;
        if (accept)
        begin
            pos_next = (cur_pos == LAST_POS) ? '0 : cur_pos + PW'(1);
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (take)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
            vld_reg      <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                vld_reg[cur_pos] <= 1'b1;
            end
        end
    end

    // read old entry and write the new byte at the same edge
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg        <= mem[cur_pos];
            rdv_reg       <= vld_reg[cur_pos];
            mem[cur_pos]  <= now;
            s1_now_reg    <= now;
            s1_pos_reg    <= cur_pos;
        end
    end

    assign prev    = rdv_reg ? rd_reg : 8'h00;
    assign pos_low = 3'(s1_pos_reg);

    // one lane per switch of the byte
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        sscd_lane #(
            .LANE (g)
        ) u_lane (
            .now_bit  (s1_now_reg[g]),
            .prev_bit (prev[g]),
            .pos_low  (pos_low),
            .res      (lanes[g])
        );
    end

    // merge lane results into an ordered event stream
    sscd_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (s1_valid_reg),
        .lanes      (lanes),
        .load_take  (take),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt_data   (evt_data)
    );

`ifndef SYNTH
    ap_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        scan_stall |-> s1_valid_reg)
        else $error("scan stalled with empty lane stage");

    ap_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("byte position out of range");

    ap_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted byte missing from lane stage");

    ap_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
        accept && scan_data.scan_start |=> pos_reg == PW'(1 % SCAN_BYTES))
        else $error("scan start did not restart byte position");
`endif

endmodule

`default_nettype wire

FILE: sv/sscd_lane.sv
// ----------------------------------------------------------------------------
// sscd_lane: one switch lane
// compares the new and previous state of one switch and forms its number
// ----------------------------------------------------------------------------
`default_nettype none

module sscd_lane #(
    parameter int unsigned LANE = 0
) (
    input  wire logic          now_bit,
    input  wire logic          prev_bit,
    input  wire logic [2:0]    pos_low,
    output sscd_pkg::lane_t    res
);
    import sscd_pkg::*;

    always_comb
    begin
        res.change = now_bit ^ prev_bit;
        res.state  = now_bit;
        // byte position times 8 plus bit, low 6 bits
        res.number = {pos_low, 3'(LANE)};
    end

endmodule

`default_nettype wire

FILE: sv/sscd_merge.sv
// ----------------------------------------------------------------------------
// sscd_merge: lane merge and event serializer
// holds the lane results of one byte and emits changed switches in order
// ----------------------------------------------------------------------------
`default_nettype none

module sscd_merge (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   load_valid,
    input  wire sscd_pkg::lane_t [sscd_pkg::LANES-1:0]  lanes,
    output logic                                        load_take,
    output logic                                        evt_valid,
    input  wire logic                                   evt_stall,
    output sscd_pkg::evt_t                              evt_data
);
    import sscd_pkg::*;

    logic [LANES-1:0] pend_reg, pend_next;
    lane_t [LANES-1:0] lane_reg;
    logic             out_valid_reg, out_valid_next;
    evt_t             out_reg, out_next;

    logic [2:0]       sel;
    logic [LANES-1:0] rest;
    logic [LANES-1:0] load_mask;
    logic             emit;
    logic             last;

    // lowest pending lane
    always_comb
    begin
        sel = '0;
        for (int j = LANES - 1; j >= 0; j--)
        begin
            if (pend_reg[j])
            begin
                sel = 3'(j);
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            load_mask[j] = lanes[j].change;
        end
        rest      = pend_reg & ~(LANES'(1) << sel);
        last      = (rest == '0);
        emit      = (pend_reg != '0) && (!out_valid_reg || !evt_stall);
        load_take = (pend_reg == '0) || (emit && last);

        pend_next = pend_reg;
        if (load_take && load_valid)
        begin
            pend_next = load_mask;
        end
        else if (emit)
        begin
            pend_next = rest;
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next         = 1'b1;
            out_next.switch_number = lane_reg[sel].number;
            out_next.switch_on     = lane_reg[sel].state;
            out_next.last_event    = last;
        end
        else if (!evt_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (load_take && load_valid)
        begin
            lane_reg <= lanes;
        end
    end

    assign evt_valid = out_valid_reg;
    assign evt_data  = out_reg;

endmodule

`default_nettype wire

FILE: dv/tb_switch_scan_change_events.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_switch_scan_change_events: testbench for the switch scan change detector
// drives scanned bytes through the valid/stall scan channel, tracks the
// previous-scan store and byte position itself, and checks every change event
// field by field in order, under random idling on both sides and a long
// receiver hold-off
// ----------------------------------------------------------------------------
`default_nettype none

module tb_switch_scan_change_events;

    import sscd_pkg::*;

    localparam int unsigned SCAN_BYTES  = 8;
    localparam int          CLK_PERIOD  = 20;
    localparam int          CYCLE_LIMIT = 200000;
    // long receiver hold-off, long enough to back the block up to its input
    localparam int          HOLD_CYCLES = 400;
    // settle time after the last event
    localparam int          TAIL_CYCLES = 12;

    logic   clk        = 1'b0;
    logic   rst_n      = 1'b0;
    logic   scan_valid = 1'b0;
    logic   scan_stall;
    scan_t  scan_data  = '0;
    logic   evt_valid;
    logic   evt_stall  = 1'b0;
    evt_t   evt_data;

    // stimulus and expectation stores
    scan_t  pending_scans[$];
    evt_t   expected_events[$];

    // shadow of the block's state, updated at each accepted scan transaction
    logic [7:0] prev_switches[SCAN_BYTES];
    logic [2:0] next_byte_pos;

    // shadow raw bytes used only to shape realistic scans
    logic [7:0] gen_raw[SCAN_BYTES];

    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     error_count   = 0;
    int     cycle_count   = 0;

    // receiver hold-off control, counted in the stall process
    logic   pressure_on   = 1'b0;
    logic   hold_done     = 1'b0;
    int     hold_count    = 0;

    switch_scan_change_events #(
        .SCAN_BYTES (SCAN_BYTES)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid),
        .scan_stall (scan_stall),
        .scan_data  (scan_data),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt_data   (evt_data)
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // predictor: one accepted byte gives one event per changed switch,
    // lowest switch first, the highest changed switch marked as last
    // ------------------------------------------------------------------------
    function automatic void predict_switch_changes(scan_t item);
        logic [7:0] now;
        logic [7:0] diff;
        logic [2:0] pos;
        int         top_bit;
        evt_t       ev;
        now     = '0;
        top_bit = 0;
        // first shifted bit (bit 7) is switch 0 of the byte
        for (int k = 0; k < 8; k++)
        begin
            now[k] = item.scan_byte[7 - k];
        end
        // scan start forces the position back to the first byte
        pos = item.scan_start ? 3'd0 : next_byte_pos;
        diff = now ^ prev_switches[pos];
        for (int j = 0; j < 8; j++)
        begin
            if (diff[j])
            begin
                top_bit = j;
            end
        end
        for (int j = 0; j < 8; j++)
        begin
            if (diff[j])
            begin
                ev.switch_number = 6'((int'(pos) * 8 + j) & 63);
                ev.switch_on     = now[j];
                ev.last_event    = (j == top_bit);
                expected_events.push_back(ev);
            end
        end
        prev_switches[pos] = now;
        // wrap after the last byte even without a scan start
        next_byte_pos = (int'(pos) == SCAN_BYTES - 1) ? 3'd0 : pos + 3'd1;
    endfunction

    // ------------------------------------------------------------------------
    // driver: presents queued bytes, holds a stalled payload, idles at random
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_valid <= 1'b0;
            scan_data  <= '0;
        end
        else
        begin
            // transaction on the scan channel: update the shadow state
            if (scan_valid && !scan_stall)
            begin
                predict_switch_changes(scan_data);
            end
            // a new byte may be loaded only when the current one is gone
            if (!scan_valid || !scan_stall)
            begin
                if (pending_scans.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    scan_data  <= pending_scans.pop_front();
                    scan_valid <= 1'b1;
                end
                else
                begin
                    scan_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver stall: random idling, plus one long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_stall  <= 1'b0;
            hold_count <= 0;
            hold_done  <= 1'b0;
        end
        else if (pressure_on && !hold_done)
        begin
            evt_stall <= 1'b1;
            if (hold_count == HOLD_CYCLES - 1)
            begin
                hold_done <= 1'b1;
            end
            hold_count <= hold_count + 1;
        end
        else
        begin
            evt_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: every event transaction against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        evt_t want;
        if (rst_n && evt_valid && !evt_stall)
        begin
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected event, expected none actual %h", $time, evt_data);
                error_count = error_count + 1;
            end
            else
            begin
                want = expected_events.pop_front();
                if (evt_data.switch_number !== want.switch_number)
                begin
                    $display("%0t: switch_number mismatch, expected %0d actual %0d",
                             $time, want.switch_number, evt_data.switch_number);
                    error_count = error_count + 1;
                end
                if (evt_data.switch_on !== want.switch_on)
                begin
                    $display("%0t: switch_on mismatch on switch %0d, expected %b actual %b",
                             $time, want.switch_number, want.switch_on, evt_data.switch_on);
                    error_count = error_count + 1;
                end
                if (evt_data.last_event !== want.last_event)
                begin
                    $display("%0t: last_event mismatch on switch %0d, expected %b actual %b",
                             $time, want.switch_number, want.last_event, evt_data.last_event);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_scan(input logic [7:0] raw, input logic start);
        scan_t item;
        item.scan_byte  = raw;
        item.scan_start = start;
        pending_scans.push_back(item);
    endtask

    // mostly whole scans with few switches moving, some cut short, some noise
    task automatic queue_random_scans(input int count);
        int         made;
        int         sel;
        int         kind;
        int         len;
        logic [7:0] b;
        made = 0;
        while (made < count)
        begin
            sel = $urandom_range(99);
            if (sel < 15)
            begin
                // noise: any byte, scan start at random
                queue_scan(8'($urandom_range(255)), 1'($urandom_range(1)));
                made++;
            end
            else
            begin
                // truncated scan now and then, otherwise a full one
                len = (sel < 25) ? $urandom_range(1, SCAN_BYTES - 1) : SCAN_BYTES;
                for (int pos = 0; pos < len; pos++)
                begin
                    kind = $urandom_range(9);
                    if (kind < 3)
                    begin
                        b = gen_raw[pos];
                    end
                    else if (kind < 8)
                    begin
                        b = gen_raw[pos] ^ (8'h01 << $urandom_range(7));
                        if ($urandom_range(1))
                        begin
                            b = b ^ (8'h01 << $urandom_range(7));
                        end
                    end
                    else
                    begin
                        b = 8'($urandom_range(255));
                    end
                    gen_raw[pos] = b;
                    queue_scan(b, pos == 0);
                    made++;
                end
            end
        end
    endtask

    // all stimulus taken, all events seen, then let the pipeline settle
    task automatic wait_drained();
        while (pending_scans.size() != 0 || scan_valid || expected_events.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // run control
    // ------------------------------------------------------------------------
    initial
    begin
        for (int k = 0; k < SCAN_BYTES; k++)
        begin
            prev_switches[k] = '0;
            gen_raw[k]       = '0;
        end
        next_byte_pos = '0;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // phase one: sender idles rarely, receiver often
        send_idle_pct = 13;
        recv_idle_pct = 73;

        // directed: no change, all switches on, single switches at both ends
        queue_scan(8'h00, 1'b1);
        queue_scan(8'hFF, 1'b0);
        queue_scan(8'h80, 1'b0);
        queue_scan(8'h01, 1'b0);
        queue_scan(8'h55, 1'b0);
        queue_scan(8'hAA, 1'b0);
        queue_scan(8'h3C, 1'b0);
        queue_scan(8'hC3, 1'b0);
        // end of scan: position wraps to the first byte without a start
        queue_scan(8'hFF, 1'b0);
        // same byte again at position one gives nothing
        queue_scan(8'hFF, 1'b0);
        // scan start mid-scan, every switch of byte zero turns off
        queue_scan(8'h00, 1'b1);
        queue_scan(8'h00, 1'b0);
        // repeated start on a single switch: change, then no change
        queue_scan(8'h80, 1'b1);
        queue_scan(8'h80, 1'b1);
        queue_scan(8'h7F, 1'b1);
        queue_scan(8'h01, 1'b0);
        wait_drained();

        queue_random_scans(150);
        wait_drained();

        // phase two: the other way round
        send_idle_pct = 73;
        recv_idle_pct = 13;
        queue_random_scans(150);
        wait_drained();

        // phase three: no idling, but the receiver holds off for a long stretch
        send_idle_pct = 0;
        recv_idle_pct = 0;
        pressure_on   = 1'b1;
        queue_random_scans(150);
        wait_drained();

        if (error_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run timed out", $time);
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
sv/sscd_pkg.sv
sv/sscd_lane.sv
sv/sscd_merge.sv
sv/switch_scan_change_events.sv
dv/tb_switch_scan_change_events.sv
